FILE: hdl/modular_exponentiation_assert.svh
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Concurrent check helpers shared by the modular exponentiation RTL.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication
`define MODEXP_ASSERT_IMPL(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define MODEXP_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hdl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, action codes and sequencer types for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int OPERAND_WIDTH = 31;
	localparam int EXP_WIDTH     = 32;
	localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

	localparam logic [OPERAND_WIDTH-1:0] MODULUS_RESET = OPERAND_WIDTH'(1000000007);

	localparam logic [1:0] ACT_POWER   = 2'd0;
	localparam logic [1:0] ACT_INVERSE = 2'd1;
	localparam logic [1:0] ACT_DIVIDE  = 2'd2;
	localparam logic [1:0] ACT_UNUSED  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SCAN,
		ST_MUL_ACC,
		ST_MUL_SQR,
		ST_FINAL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		X_INPUT,
		X_DIVIDEND,
		X_ACC,
		X_BASE
	} x_sel_t;

	typedef enum logic [1:0] {
		Y_ONE,
		Y_ACC,
		Y_BASE
	} y_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_ACC,
		RES_PROD
	} res_sel_t;

endpackage

FILE: hdl/modexp_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation channel interfaces
// Request, response and modulus write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface modexp_req_if import modexp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic [OPERAND_WIDTH-1:0]  operand_a;
	logic [OPERAND_WIDTH-1:0]  operand_b;
	logic [EXP_WIDTH-1:0]      exponent;

	modport source (output valid, action, operand_a, operand_b, exponent, input ready);
	modport sink   (input valid, action, operand_a, operand_b, exponent, output ready);
endinterface

interface modexp_rsp_if import modexp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OPERAND_WIDTH-1:0]  result;

	modport source (output valid, result, input ready);
	modport sink   (input valid, result, output ready);
endinterface

interface modexp_cfg_if import modexp_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OPERAND_WIDTH-1:0]  modulus;

	modport source (output valid, modulus, input ready);
	modport sink   (input valid, modulus, output ready);
endinterface

FILE: hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square-and-multiply under a configured modulus, with power,
// Fermat inverse and modular division modes on one bit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item (action, operand_a, operand_b, exponent); rsp returns
//   one result per item; cfg writes the modulus (reset value 1000000007) and
//   is taken only while the block is idle with no request pending.
//   One item is worked at a time; req.ready is high only in idle.
//   Every modular multiply runs on one shared interleaved multiplier, one
//   operand bit per cycle.
//   In inverse and division modes the exponent is taken as modulus-2;
//   division mode then multiplies the result by operand_a.
//   A modulus below 2 or action 3 returns 0.
//   The result sits in an output register: a new item is taken while it
//   waits, and a finished item stalls in the done state until rsp is free.
//   Reset clears the sequencer and output valid and reloads the modulus.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_assert.svh"

module modular_exponentiation import modexp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	modexp_req_if.sink      req,
	modexp_rsp_if.source    rsp,
	modexp_cfg_if.sink      cfg
);

	localparam int W = OPERAND_WIDTH;

	state_t state_q, state_d;

	logic [W-1:0]          mod_q;
	logic [W-1:0]          a_q;
	logic [W-1:0]          acc_q;
	logic [W-1:0]          base_q;
	logic [W-1:0]          res_q;
	logic [W-1:0]          rsp_data_q;
	logic                  rsp_valid_q;
	logic [1:0]            act_q;
	logic [EXP_WIDTH-1:0]  exp_q;

	logic [W-1:0]          mx_q, my_q, mr_q;
	logic [CNT_WIDTH-1:0]  mcnt_q;

	logic                  mul_load, mul_busy, mul_last;
	x_sel_t                x_sel;
	y_sel_t                y_sel;
	res_sel_t              res_sel;
	logic                  ld_item, ld_acc, ld_base, ld_res, shift_exp, rsp_load;
	logic                  degenerate;

	logic [W-1:0]          x_val, y_val, prod;
	logic [W+1:0]          sum;
	logic [W+2:0]          dif1, dif2;

	assign req.ready  = (state_q == ST_IDLE);
	assign cfg.ready  = (state_q == ST_IDLE) && !req.valid;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = rsp_data_q;

	assign degenerate = (mod_q < W'(2)) || (req.action == ACT_UNUSED);
	assign mul_busy   = (state_q == ST_REDUCE) || (state_q == ST_MUL_ACC) ||
	                    (state_q == ST_MUL_SQR) || (state_q == ST_FINAL);
	assign mul_last   = (mcnt_q == '0);

	// interleaved step: r = 2r + bit*y, then fold back below the modulus
	assign sum  = {1'b0, mr_q, 1'b0} + (mx_q[W-1] ? {2'b00, my_q} : '0);
	assign dif1 = {1'b0, sum} - {3'b000, mod_q};
	assign dif2 = {1'b0, sum} - {2'b00, mod_q, 1'b0};
	assign prod = !dif2[W+2] ? dif2[W-1:0] :
	              !dif1[W+2] ? dif1[W-1:0] : sum[W-1:0];

	always_comb begin
		case (x_sel)
			X_INPUT:    x_val = (req.action == ACT_DIVIDE) ? req.operand_b : req.operand_a;
			X_DIVIDEND: x_val = a_q;
			X_ACC:      x_val = acc_q;
			X_BASE:     x_val = base_q;
			default:    x_val = base_q;
		endcase
		case (y_sel)
			Y_ONE:   y_val = W'(1);
			Y_ACC:   y_val = acc_q;
			Y_BASE:  y_val = base_q;
			default: y_val = base_q;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		mul_load  = 1'b0;
		x_sel     = X_BASE;
		y_sel     = Y_BASE;
		res_sel   = RES_PROD;
		ld_item   = 1'b0;
		ld_acc    = 1'b0;
		ld_base   = 1'b0;
		ld_res    = 1'b0;
		shift_exp = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					ld_item = 1'b1;
					if (degenerate) begin
						ld_res  = 1'b1;
						res_sel = RES_ZERO;
						state_d = ST_DONE;
					end else begin
						mul_load = 1'b1;
						x_sel    = X_INPUT;
						y_sel    = Y_ONE;
						state_d  = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (mul_last) begin
					ld_base = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (exp_q == '0) begin
					if (act_q == ACT_DIVIDE) begin
						mul_load = 1'b1;
						x_sel    = X_DIVIDEND;
						y_sel    = Y_ACC;
						state_d  = ST_FINAL;
					end else begin
						ld_res  = 1'b1;
						res_sel = RES_ACC;
						state_d = ST_DONE;
					end
				end else if (exp_q[0]) begin
					mul_load = 1'b1;
					x_sel    = X_ACC;
					y_sel    = Y_BASE;
					state_d  = ST_MUL_ACC;
				end else begin
					mul_load = 1'b1;
					state_d  = ST_MUL_SQR;
				end
			end
			ST_MUL_ACC: begin
				if (mul_last) begin
					ld_acc   = 1'b1;
					mul_load = 1'b1;
					state_d  = ST_MUL_SQR;
				end
			end
			ST_MUL_SQR: begin
				if (mul_last) begin
					ld_base   = 1'b1;
					shift_exp = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_FINAL: begin
				if (mul_last) begin
					ld_res  = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			mod_q       <= MODULUS_RESET;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				mod_q <= cfg.modulus;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_item) begin
			act_q <= req.action;
			a_q   <= req.operand_a;
			acc_q <= W'(1);
			if (req.action == ACT_POWER) begin
				exp_q <= req.exponent;
			end else begin
				exp_q <= EXP_WIDTH'(mod_q - W'(2));
			end
		end
		if (ld_acc) begin
			acc_q <= prod;
		end
		if (ld_base) begin
			base_q <= prod;
		end
		if (shift_exp) begin
			exp_q <= exp_q >> 1;
		end
		if (ld_res) begin
			case (res_sel)
				RES_ZERO: res_q <= '0;
				RES_ACC:  res_q <= acc_q;
				RES_PROD: res_q <= prod;
				default:  res_q <= '0;
			endcase
		end
		if (rsp_load) begin
			rsp_data_q <= res_q;
		end
		if (mul_load) begin
			mx_q   <= x_val;
			my_q   <= y_val;
			mr_q   <= '0;
			mcnt_q <= CNT_WIDTH'(W - 1);
		end else if (mul_busy) begin
			mx_q   <= mx_q << 1;
			mr_q   <= prod;
			mcnt_q <= mcnt_q - CNT_WIDTH'(1);
		end
	end

	`MODEXP_ASSERT_NEXT(a_req_starts, clk, arst_n, req.valid && req.ready, state_q != ST_IDLE, "accepted item left sequencer idle")
	`MODEXP_ASSERT_NEXT(a_mul_hold, clk, arst_n, mul_busy && (mcnt_q != '0), state_q == $past(state_q), "multiply state left before last bit")
	`MODEXP_ASSERT_IMPL(a_scan_range, clk, arst_n, state_q == ST_SCAN, (acc_q < mod_q) && (base_q < mod_q), "residue not below modulus")
	`MODEXP_ASSERT_NEXT(a_rsp_load, clk, arst_n, rsp_load, rsp_valid_q && (state_q == ST_IDLE), "finished item not presented")

endmodule
